// ===== rtl/card_machine_cpu_phase1_assert.svh =====
// Assertion macros used by the checker of the card machine.
`ifndef CARD_MACHINE_CPU_PHASE1_ASSERT_SVH
`define CARD_MACHINE_CPU_PHASE1_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CMC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cmc_pkg.sv =====
// Shared constants, codes and widths of the card machine.
`timescale 1ns / 1ps
package cmc_pkg;

  localparam int MEM_WORDS  = 100;
  localparam int LINE_WORDS = 10;

  localparam int AW       = $clog2(MEM_WORDS);
  localparam int PTR_W    = 7;
  localparam int LC_W     = $clog2(LINE_WORDS + 1);
  localparam int KIND_W   = 3;
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 4;
  localparam int WORD_W   = 32;

  localparam logic [PTR_W-1:0] MEM_PTR = PTR_W'(MEM_WORDS);

  localparam logic [KIND_W-1:0] KIND_NEW_JOB = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PROG    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STEP    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CARD    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MISSING = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 4'd0;
  localparam logic [STATUS_W-1:0] ST_OUT      = 4'd1;
  localparam logic [STATUS_W-1:0] ST_WAIT     = 4'd2;
  localparam logic [STATUS_W-1:0] ST_HALTED   = 4'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 4'd4;
  localparam logic [STATUS_W-1:0] ST_BADADDR  = 4'd5;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 4'd6;
  localparam logic [STATUS_W-1:0] ST_PCRANGE  = 4'd7;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 4'd8;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_G     = 8'h47;
  localparam logic [CHAR_W-1:0] CH_P     = 8'h50;
  localparam logic [CHAR_W-1:0] CH_H     = 8'h48;
  localparam logic [CHAR_W-1:0] CH_L     = 8'h4C;
  localparam logic [CHAR_W-1:0] CH_S     = 8'h53;
  localparam logic [CHAR_W-1:0] CH_C     = 8'h43;
  localparam logic [CHAR_W-1:0] CH_B     = 8'h42;
  localparam logic [CHAR_W-1:0] CH_D     = 8'h44;
  localparam logic [CHAR_W-1:0] CH_R     = 8'h52;
  localparam logic [CHAR_W-1:0] CH_T     = 8'h54;

  localparam logic [WORD_W-1:0] SPACE_WORD = {4{CH_SPACE}};

endpackage

// ===== rtl/cmc_ifs.sv =====
// Request and result channel interfaces of the card machine.
`timescale 1ns / 1ps
interface cmc_in_if;
  import cmc_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CHAR_W-1:0] char_in;
  logic              has_char;
  logic              line_end;

  modport source (output valid, kind, char_in, has_char, line_end, input ready);
  modport sink (input valid, kind, char_in, has_char, line_end, output ready);
endinterface

interface cmc_out_if;
  import cmc_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CHAR_W-1:0]   out_char;
  logic                last;
  logic                compare_flag;
  logic [PTR_W-1:0]    pc;

  modport source (output valid, status, out_char, last, compare_flag, pc, input ready);
  modport sink (input valid, status, out_char, last, compare_flag, pc, output ready);
endinterface

// ===== rtl/card_machine_cpu_phase1.sv =====
// Top level of the card machine: word memory, sequencer and result register.
// A request is taken only in S_IDLE, and the next one only once the sequencer is back
// there: a stored byte passes S_MERGE, an executed step S_DECODE (then S_LOAD, S_RESP,
// S_PD_OUT or S_NL). PD gives 41 bytes at one a cycle while the output is not stalled.
// Reset: synchronous, active low; per-word valid bits clear at once, so memory
// reads as spaces from the first cycle with no clearing pass. New job does the same.
`timescale 1ns / 1ps
module card_machine_cpu_phase1 (
  input logic       clk,
  input logic       rst_n,
  cmc_in_if.sink    in_ch,
  cmc_out_if.source out_ch
);
  import cmc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MERGE, S_DECODE, S_LOAD, S_RESP, S_PD_OUT, S_NL
  } state_t;

  state_t state_r;

  logic [WORD_W-1:0] mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] vld_r;
  logic [WORD_W-1:0] rdata_r;
  logic              rvalid_r;

  logic              mem_re, mem_we;
  logic [AW-1:0]     mem_ra, mem_wa;
  logic [WORD_W-1:0] mem_wd;

  logic [WORD_W-1:0] reg_r_r;
  logic [PTR_W-1:0]  ic_r;
  logic              c_r;
  logic [PTR_W-1:0]  load_ptr_r, load_ptr_nxt;
  logic [1:0]        load_phase_r, load_phase_nxt;
  logic [PTR_W-1:0]  card_ptr_r;
  logic [1:0]        card_phase_r;
  logic              awaiting_r;
  logic              halted_r;

  logic [PTR_W-1:0]  wr_addr_r;
  logic [1:0]        wr_lane_r;
  logic [CHAR_W-1:0] wr_char_r;
  logic [STATUS_W-1:0] resp_status_r;
  logic              nl_left_r;
  logic              op_l_r;
  logic [PTR_W-1:0]  pd_ptr_r;
  logic [1:0]        pd_lane_r;
  logic [LC_W-1:0]   pd_cnt_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [CHAR_W-1:0]   out_char_r;
  logic                out_last_r;
  logic                out_c_r;
  logic [PTR_W-1:0]    out_pc_r;

  logic accept, out_free, out_load;
  logic prog_wr, card_wr, step_go;

  // decode of the fetched instruction word
  logic [WORD_W-1:0] word;
  logic [CHAR_W-1:0] op0, op1, d_hi, d_lo;
  logic [CHAR_W-1:0] hi_sub, lo_sub;
  logic [3:0]        hi_d, lo_d;
  logic [PTR_W-1:0]  addr_val;
  logic              addr_ok, pd_ok, known, dec_go;
  logic              is_h, is_bt, is_g, is_p, is_l, is_s, is_c;
  logic [WORD_W-1:0] merged;
  logic [CHAR_W-1:0] pd_byte;
  logic              pd_more;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign out_load    = out_free &&
                       (state_r == S_RESP || state_r == S_PD_OUT || state_r == S_NL);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.out_char     = out_char_r;
  assign out_ch.last         = out_last_r;
  assign out_ch.compare_flag = out_c_r;
  assign out_ch.pc           = out_pc_r;

  assign prog_wr = in_ch.has_char && (load_ptr_r < MEM_PTR);
  assign card_wr = awaiting_r && in_ch.has_char && (card_ptr_r < MEM_PTR);
  assign step_go = !halted_r && !awaiting_r && (ic_r < MEM_PTR);

  assign word = rvalid_r ? rdata_r : SPACE_WORD;
  assign op0  = word[7:0];
  assign op1  = word[15:8];
  assign d_hi = word[23:16];
  assign d_lo = word[31:24];

  assign hi_sub   = d_hi - CH_ZERO;
  assign lo_sub   = d_lo - CH_ZERO;
  assign hi_d     = hi_sub[3:0];
  assign lo_d     = lo_sub[3:0];
  assign addr_val = PTR_W'({hi_d, 3'b000}) + PTR_W'({hi_d, 1'b0}) + PTR_W'(lo_d);
  assign addr_ok  = (d_hi >= CH_ZERO) && (d_hi <= CH_NINE) &&
                    (d_lo >= CH_ZERO) && (d_lo <= CH_NINE) && (addr_val < MEM_PTR);
  assign pd_ok    = ({1'b0, addr_val} + 8'(LINE_WORDS)) <= 8'(MEM_WORDS);

  assign is_h   = (op0 == CH_H);
  assign is_bt  = (op0 == CH_B) && (op1 == CH_T);
  assign is_g   = (op0 == CH_G) && (op1 == CH_D);
  assign is_p   = (op0 == CH_P) && (op1 == CH_D);
  assign is_l   = (op0 == CH_L) && (op1 == CH_R);
  assign is_s   = (op0 == CH_S) && (op1 == CH_R);
  assign is_c   = (op0 == CH_C) && (op1 == CH_R);
  assign known  = is_g || is_p || is_l || is_s || is_c;
  assign dec_go = !is_h && !is_bt && known && addr_ok;

  assign pd_byte = word[{pd_lane_r, 3'b000} +: CHAR_W];
  assign pd_more = (pd_cnt_r != LC_W'(LINE_WORDS - 1));

  always_comb begin
    merged = word;
    for (int j = 0; j < 4; j++) begin
      if (wr_lane_r == 2'(j)) merged[8*j +: 8] = wr_char_r;
    end
  end

  // program load pointer: advance a lane per byte and a word per four, round up on a line end
  always_comb begin
    load_ptr_nxt   = load_ptr_r;
    load_phase_nxt = load_phase_r;
    if (prog_wr) begin
      if (load_phase_r == 2'd3) begin
        load_phase_nxt = 2'd0;
        load_ptr_nxt   = load_ptr_r + PTR_W'(1);
      end else begin
        load_phase_nxt = load_phase_r + 2'd1;
      end
    end
    if (in_ch.line_end && load_phase_nxt != 2'd0) begin
      load_phase_nxt = 2'd0;
      if (load_ptr_nxt < MEM_PTR) load_ptr_nxt = load_ptr_nxt + PTR_W'(1);
    end
  end

  // memory port control
  always_comb begin
    mem_re = 1'b0;
    mem_ra = ic_r[AW-1:0];
    mem_we = 1'b0;
    mem_wa = wr_addr_r[AW-1:0];
    mem_wd = merged;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.kind == KIND_PROG && prog_wr) begin
            mem_re = 1'b1;
            mem_ra = load_ptr_r[AW-1:0];
          end else if (in_ch.kind == KIND_CARD && card_wr) begin
            mem_re = 1'b1;
            mem_ra = card_ptr_r[AW-1:0];
          end else if (in_ch.kind == KIND_STEP && step_go) begin
            mem_re = 1'b1;
            mem_ra = ic_r[AW-1:0];
          end
        end
      end
      S_MERGE: mem_we = 1'b1;
      S_DECODE: begin
        mem_ra = addr_val[AW-1:0];
        mem_wa = addr_val[AW-1:0];
        mem_wd = reg_r_r;
        if (dec_go && is_s) mem_we = 1'b1;
        if (dec_go && ((is_p && pd_ok) || is_l || is_c)) mem_re = 1'b1;
      end
      S_PD_OUT: begin
        mem_ra = pd_ptr_r[AW-1:0] + AW'(1);
        if (out_free && pd_lane_r == 2'd3 && pd_more) mem_re = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) begin
      rdata_r  <= mem[mem_ra];
      rvalid_r <= vld_r[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      vld_r        <= '0;
      reg_r_r      <= SPACE_WORD;
      ic_r         <= '0;
      c_r          <= 1'b0;
      load_ptr_r   <= '0;
      load_phase_r <= '0;
      card_ptr_r   <= '0;
      card_phase_r <= '0;
      awaiting_r   <= 1'b0;
      halted_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (mem_we) vld_r[mem_wa] <= 1'b1;

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            wr_char_r <= in_ch.char_in;
            case (in_ch.kind)
              KIND_NEW_JOB: begin
                resp_status_r <= ST_OK;
                state_r       <= S_RESP;
                vld_r         <= '0;
                reg_r_r       <= SPACE_WORD;
                ic_r          <= '0;
                c_r           <= 1'b0;
                load_ptr_r    <= '0;
                load_phase_r  <= '0;
                card_ptr_r    <= '0;
                card_phase_r  <= '0;
                awaiting_r    <= 1'b0;
                halted_r      <= 1'b0;
              end
              KIND_PROG: begin
                resp_status_r <= (in_ch.has_char && !prog_wr) ? ST_OVERFLOW : ST_OK;
                wr_addr_r     <= load_ptr_r;
                wr_lane_r     <= load_phase_r;
                load_ptr_r    <= load_ptr_nxt;
                load_phase_r  <= load_phase_nxt;
                state_r       <= prog_wr ? S_MERGE : S_RESP;
              end
              KIND_CARD: begin
                if (!awaiting_r) begin
                  resp_status_r <= ST_IGNORED;
                  state_r       <= S_RESP;
                end else begin
                  resp_status_r <= (in_ch.has_char && !card_wr) ? ST_OVERFLOW : ST_OK;
                  wr_addr_r     <= card_ptr_r;
                  wr_lane_r     <= card_phase_r;
                  state_r       <= card_wr ? S_MERGE : S_RESP;
                  if (card_wr) begin
                    card_phase_r <= card_phase_r + 2'd1;
                    if (card_phase_r == 2'd3) card_ptr_r <= card_ptr_r + PTR_W'(1);
                  end
                  if (in_ch.line_end) awaiting_r <= 1'b0;
                end
              end
              KIND_STEP: begin
                if (halted_r) resp_status_r <= ST_HALTED;
                else if (awaiting_r) resp_status_r <= ST_WAIT;
                else if (!step_go) resp_status_r <= ST_PCRANGE;
                else resp_status_r <= ST_OK;
                if (step_go) begin
                  ic_r    <= ic_r + PTR_W'(1);
                  state_r <= S_DECODE;
                end else begin
                  state_r <= S_RESP;
                end
              end
              KIND_MISSING: begin
                resp_status_r <= awaiting_r ? ST_OK : ST_IGNORED;
                awaiting_r    <= 1'b0;
                state_r       <= S_RESP;
              end
              default: begin
                resp_status_r <= ST_IGNORED;
                state_r       <= S_RESP;
              end
            endcase
          end
        end

        S_MERGE: state_r <= S_RESP;

        S_DECODE: begin
          if (is_h) begin
            halted_r  <= 1'b1;
            nl_left_r <= 1'b1;
            state_r   <= S_NL;
          end else if (is_bt) begin
            state_r       <= S_RESP;
            resp_status_r <= (c_r && !addr_ok) ? ST_BADADDR : ST_OK;
            if (c_r && addr_ok) ic_r <= addr_val;
          end else if (!known) begin
            resp_status_r <= ST_UNKNOWN;
            state_r       <= S_RESP;
          end else if (!addr_ok) begin
            resp_status_r <= ST_BADADDR;
            state_r       <= S_RESP;
          end else if (is_g) begin
            awaiting_r    <= 1'b1;
            card_ptr_r    <= addr_val;
            card_phase_r  <= 2'd0;
            resp_status_r <= ST_WAIT;
            state_r       <= S_RESP;
          end else if (is_p) begin
            if (!pd_ok) begin
              resp_status_r <= ST_BADADDR;
              state_r       <= S_RESP;
            end else begin
              pd_ptr_r  <= addr_val;
              pd_lane_r <= 2'd0;
              pd_cnt_r  <= '0;
              state_r   <= S_PD_OUT;
            end
          end else if (is_s) begin
            resp_status_r <= ST_OK;
            state_r       <= S_RESP;
          end else begin
            resp_status_r <= ST_OK;
            op_l_r        <= is_l;
            state_r       <= S_LOAD;
          end
        end

        S_LOAD: begin
          if (op_l_r) reg_r_r <= word;
          else c_r <= (reg_r_r == word);
          state_r <= S_RESP;
        end

        S_RESP: begin
          if (out_free) begin
            out_status_r <= resp_status_r;
            out_char_r   <= '0;
            out_last_r   <= 1'b1;
            out_c_r      <= c_r;
            out_pc_r     <= ic_r;
            state_r      <= S_IDLE;
          end
        end

        S_PD_OUT: begin
          if (out_free) begin
            out_status_r <= ST_OUT;
            out_char_r   <= pd_byte;
            out_last_r   <= 1'b0;
            out_c_r      <= c_r;
            out_pc_r     <= ic_r;
            pd_lane_r    <= pd_lane_r + 2'd1;
            if (pd_lane_r == 2'd3) begin
              if (pd_more) begin
                pd_ptr_r <= pd_ptr_r + PTR_W'(1);
                pd_cnt_r <= pd_cnt_r + LC_W'(1);
              end else begin
                nl_left_r <= 1'b0;
                state_r   <= S_NL;
              end
            end
          end
        end

        S_NL: begin
          if (out_free) begin
            out_status_r <= ST_OUT;
            out_char_r   <= CH_NL;
            out_last_r   <= !nl_left_r;
            out_c_r      <= c_r;
            out_pc_r     <= ic_r;
            if (nl_left_r) nl_left_r <= 1'b0;
            else state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/cmc_checker.sv =====
// Port-level checker for the card machine and its bind to the top level.
`timescale 1ns / 1ps
`include "card_machine_cpu_phase1_assert.svh"
module cmc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [cmc_pkg::STATUS_W-1:0] out_status,
  input logic [cmc_pkg::CHAR_W-1:0]   out_char,
  input logic                         out_last
);
  import cmc_pkg::*;

  // one request at a time: the sequencer is busy right after taking one
  `CMC_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready held after request")
  // no new request while a burst of results is still under way
  `CMC_ASSERT_SAME(a_no_req_mid_burst, out_valid && !out_last, !in_ready, "request open mid burst")
  // only output bytes come in bursts
  `CMC_ASSERT_SAME(a_single_status, out_valid && out_status != ST_OUT, out_last, "status not last")
  // hold a stalled result
  `CMC_ASSERT_NEXT(a_hold_stalled, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_char) && $stable(out_last), "stalled result changed")

endmodule

bind card_machine_cpu_phase1 cmc_checker u_cmc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_char   (out_ch.out_char),
  .out_last   (out_ch.last)
);
